@@ src/tmlp_pkg.sv @@
`timescale 1ns / 1ps
package tmlp_pkg;

  localparam int KEY_W   = 16;
  localparam int WGT_W   = 16;
  localparam int LOGIT_W = 31;
  // unsigned 31-bit activation times signed 16-bit weight
  localparam int PROD_W  = 48;

  localparam int HIDDEN_ONE_DEF = 8;
  localparam int HIDDEN_TWO_DEF = 4;
  localparam int TAB_ONE = 8;
  localparam int TAB_TWO = 4;

  localparam logic [LOGIT_W-1:0] SAT31 = {LOGIT_W{1'b1}};

  localparam logic signed [WGT_W-1:0] W1_TAB [TAB_ONE] = '{
    16'sd2642, 16'sd8522, 16'sd6693, 16'sd570,
    -16'sd4470, 16'sd6910, -16'sd8295, -16'sd6953
  };

  localparam logic signed [WGT_W-1:0] W2_TAB [TAB_ONE][TAB_TWO] = '{
    '{ 16'sd6462,   16'sd1569,   16'sd5453,  -16'sd883  },
    '{ -16'sd494,   16'sd5020,  -16'sd10696, -16'sd2701 },
    '{ 16'sd1144,   16'sd5269,   16'sd8514,  -16'sd10876 },
    '{ 16'sd4609,   16'sd4321,   16'sd353,    16'sd9242 },
    '{ 16'sd7336,   16'sd9510,  -16'sd4156,   16'sd9056 },
    '{ 16'sd10414,  16'sd5125,   16'sd6077,   16'sd2904 },
    '{ -16'sd6055, -16'sd11422,  16'sd10835,  16'sd3783 },
    '{ -16'sd10399, 16'sd4688,  -16'sd10747,  16'sd3128 }
  };

  localparam logic signed [WGT_W-1:0] W3_TAB [TAB_TWO] = '{
    16'sd10128, -16'sd4784, -16'sd6722, 16'sd124
  };

  // weights outside the trained table are zero
  function automatic logic signed [WGT_W-1:0] weight1(int j);
    return (j < TAB_ONE) ? W1_TAB[j] : '0;
  endfunction

  function automatic logic signed [WGT_W-1:0] weight2(int j, int k);
    return (j < TAB_ONE && k < TAB_TWO) ? W2_TAB[j][k] : '0;
  endfunction

  function automatic logic signed [WGT_W-1:0] weight3(int k);
    return (k < TAB_TWO) ? W3_TAB[k] : '0;
  endfunction

  // ReLU, round half up by shift, clamp to 31 bits
  function automatic logic [LOGIT_W-1:0] relu_round_sat(logic signed [63:0] v, int shift);
    logic [63:0] u;
    u = '0;
    if (v > 0) begin
      u = (64'(v) + (64'd1 << (shift - 1))) >> shift;
    end
    if (u > 64'(SAT31)) begin
      u = 64'(SAT31);
    end
    return u[LOGIT_W-1:0];
  endfunction

endpackage

@@ src/tmlp_key_if.sv @@
`timescale 1ns / 1ps
interface tmlp_key_if
  import tmlp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

@@ src/tmlp_res_if.sv @@
`timescale 1ns / 1ps
interface tmlp_res_if
  import tmlp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_out;
  logic [LOGIT_W-1:0]      logit;

  modport source (output valid, output key_out, output logit, input ready);
  modport sink (input valid, input key_out, input logit, output ready);
endinterface

@@ src/tiny_mlp_relu_inference.sv @@
`timescale 1ns / 1ps
// Throughput: one key per cycle while result.ready is high; each of the 7 stages
//   stalls on its own, so bubbles close up while the output waits.
// Reset (rst, synchronous): clears all stage valid bits; payload is not reset.
module tiny_mlp_relu_inference
  import tmlp_pkg::*;
#(
  parameter int HIDDEN_ONE = HIDDEN_ONE_DEF,
  parameter int HIDDEN_TWO = HIDDEN_TWO_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tmlp_key_if.sink    key_in,
  tmlp_res_if.source  result
);

  localparam int NSTG = 7;
  localparam int S2_W = PROD_W + $clog2(HIDDEN_ONE) + 1;
  localparam int S3_W = PROD_W + $clog2(HIDDEN_TWO) + 1;

  logic [NSTG-1:0]         v;
  logic [NSTG-1:0]         en;
  logic signed [KEY_W-1:0] key_pipe [NSTG];

  logic [LOGIT_W-1:0]       h1 [HIDDEN_ONE];
  logic signed [PROD_W-1:0] p2 [HIDDEN_TWO][HIDDEN_ONE];
  logic signed [S2_W-1:0]   s2 [HIDDEN_TWO];
  logic [LOGIT_W-1:0]       h2 [HIDDEN_TWO];
  logic signed [PROD_W-1:0] p3 [HIDDEN_TWO];
  logic signed [S3_W-1:0]   s3;
  logic [LOGIT_W-1:0]       logit_r;

  // a stage loads when it is empty or the next one takes its item
  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || result.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign key_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= key_in.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      key_pipe[0] <= key_in.key;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) begin
        key_pipe[i] <= key_pipe[i-1];
      end
    end
  end

  // stage 0: layer one with ReLU
  for (genvar j = 0; j < HIDDEN_ONE; j++) begin : g_l1
    logic signed [2*KEY_W-1:0] p1;
    assign p1 = key_in.key * weight1(j);
    always_ff @(posedge clk) begin
      if (en[0]) begin
        h1[j] <= p1[2*KEY_W-1] ? '0 : p1[LOGIT_W-1:0];
      end
    end
  end

  // stage 1: layer two products
  for (genvar k = 0; k < HIDDEN_TWO; k++) begin : g_l2
    for (genvar j = 0; j < HIDDEN_ONE; j++) begin : g_prod
      logic signed [PROD_W-1:0] p;
      assign p = $signed({1'b0, h1[j]}) * weight2(j, k);
      always_ff @(posedge clk) begin
        if (en[1]) begin
          p2[k][j] <= p;
        end
      end
    end

    // stage 2: layer two sums
    tmlp_acc #(
      .N     (HIDDEN_ONE),
      .IN_W  (PROD_W),
      .OUT_W (S2_W)
    ) u_acc2 (
      .clk   (clk),
      .en    (en[2]),
      .terms (p2[k]),
      .sum   (s2[k])
    );

    // stage 3: ReLU and requantize to Q7.24; stage 4: layer three product
    always_ff @(posedge clk) begin
      if (en[3]) begin
        h2[k] <= relu_round_sat(64'(s2[k]), 16);
      end
      if (en[4]) begin
        p3[k] <= $signed({1'b0, h2[k]}) * weight3(k);
      end
    end
  end

  // stage 5: layer three sum
  tmlp_acc #(
    .N     (HIDDEN_TWO),
    .IN_W  (PROD_W),
    .OUT_W (S3_W)
  ) u_acc3 (
    .clk   (clk),
    .en    (en[5]),
    .terms (p3),
    .sum   (s3)
  );

  // stage 6: output register
  always_ff @(posedge clk) begin
    if (en[6]) begin
      logit_r <= relu_round_sat(64'(s3), 14);
    end
  end

  assign result.valid   = v[NSTG-1];
  assign result.key_out = key_pipe[NSTG-1];
  assign result.logit   = logit_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    key_in.valid && key_in.ready |=> v[0])
    else $error("accepted request did not enter stage 0");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&v) && !result.ready |-> !key_in.ready)
    else $error("input ready while pipeline full and output stalled");

  a_zero_key: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.key_out == '0 |-> result.logit == '0)
    else $error("zero key gave a nonzero logit");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !v[NSTG-2] |=> !result.valid)
    else $error("result repeated after it was taken");

endmodule

@@ src/tmlp_acc.sv @@
`timescale 1ns / 1ps
// Registered sum of N signed terms.
module tmlp_acc
  import tmlp_pkg::*;
#(
  parameter int N     = HIDDEN_ONE_DEF,
  parameter int IN_W  = PROD_W,
  parameter int OUT_W = PROD_W + $clog2(HIDDEN_ONE_DEF) + 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [IN_W-1:0]  terms [N],
  output logic signed [OUT_W-1:0] sum
);

  logic signed [OUT_W-1:0] total;

  always_comb begin
    total = '0;
    for (int i = 0; i < N; i++) begin
      total = total + OUT_W'(terms[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= total;
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import tmlp_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int MAX_REPORTS = 50;

  // trained weights, signed Q2.14
  localparam int L1_WEIGHT [8] = '{2642, 8522, 6693, 570, -4470, 6910, -8295, -6953};
  localparam int L2_WEIGHT [8][4] = '{
    '{  6462,   1569,   5453,   -883},
    '{  -494,   5020, -10696,  -2701},
    '{  1144,   5269,   8514, -10876},
    '{  4609,   4321,    353,   9242},
    '{  7336,   9510,  -4156,   9056},
    '{ 10414,   5125,   6077,   2904},
    '{ -6055, -11422,  10835,   3783},
    '{-10399,   4688, -10747,   3128}
  };
  localparam int L3_WEIGHT [4] = '{10128, -4784, -6722, 124};

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LOGIT_W-1:0]      logit;
  } score_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tmlp_key_if key_ch ();
  tmlp_res_if res_ch ();

  tiny_mlp_relu_inference dut (
    .clk    (clk),
    .rst    (rst),
    .key_in (key_ch),
    .result (res_ch)
  );

  score_t pending_scores[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     src_gap_max = 0;
  int     sink_stall_max = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ReLU, round half up, clamp to 31 bits
  function automatic longint relu_requant(longint acc, int shift);
    longint q;
    if (acc <= 0) return 0;
    q = (acc + (longint'(1) << (shift - 1))) >>> shift;
    return (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
  endfunction

  function automatic score_t score_key(logic signed [KEY_W-1:0] k);
    longint hid_a [8];
    longint hid_b [4];
    longint acc;
    longint prod;
    score_t s;
    for (int j = 0; j < 8; j++) begin
      prod = longint'(k) * L1_WEIGHT[j];
      hid_a[j] = (prod > 0) ? prod : 0;
    end
    for (int n = 0; n < 4; n++) begin
      acc = 0;
      for (int j = 0; j < 8; j++) acc += hid_a[j] * L2_WEIGHT[j][n];
      hid_b[n] = relu_requant(acc, 16);
    end
    acc = 0;
    for (int n = 0; n < 4; n++) acc += hid_b[n] * L3_WEIGHT[n];
    s.key = k;
    s.logit = LOGIT_W'(relu_requant(acc, 14));
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_key(input logic signed [KEY_W-1:0] k);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    repeat (gap) begin
      @(negedge clk);
      key_ch.valid <= 1'b0;
    end
    @(negedge clk);
    key_ch.valid <= 1'b1;
    key_ch.key   <= k;
    do @(posedge clk); while (!key_ch.ready);
    pending_scores.push_back(score_key(k));
  endtask

  // drop valid and hold off until every pending score has come back
  task automatic wait_drain();
    @(negedge clk);
    key_ch.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] random_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = KEY_W'($urandom());
      1: k = KEY_W'($urandom_range(0, 8192)) - 16'sd4096;
      2: begin
        k = 16'sd1 <<< $urandom_range(0, KEY_W - 1);
        if ($urandom_range(0, 1)) k = -k;
      end
      default: k = $urandom_range(0, 1) ? 16'sh7FFF - KEY_W'($urandom_range(0, 255))
                                        : 16'sh8000 + KEY_W'($urandom_range(0, 255));
    endcase
    return k;
  endfunction

  // sink side: per result, stall a random number of cycles then take it
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      repeat (stall) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  always @(posedge clk) begin
    score_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch($sformatf("unexpected result key_out=%0d logit=%0d",
                                  res_ch.key_out, res_ch.logit));
      end else begin
        want = pending_scores.pop_front();
        if (res_ch.key_out !== want.key)
          report_mismatch($sformatf("key_out got %0d want %0d", res_ch.key_out, want.key));
        if (res_ch.logit !== want.logit)
          report_mismatch($sformatf("logit got %0d want %0d (key %0d)",
                                    res_ch.logit, want.logit, want.key));
      end
    end
  end

  task automatic test_directed_keys();
    logic signed [KEY_W-1:0] keys [$];
    src_gap_max = 14;
    sink_stall_max = 14;
    // zero, unit steps, both extremes, +/-1.0, bit patterns, mixed signs
    keys = '{16'sd0, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000, 16'sh8001, 16'sh7FFE,
             16'sd4096, -16'sd4096, 16'sh5555, 16'shAAAA, 16'sd2048, -16'sd2048,
             16'sd12288, -16'sd12288, 16'sh00FF, 16'shFF00, 16'sd3, -16'sd3,
             16'sd20000, -16'sd20000};
    foreach (keys[i]) send_key(keys[i]);
    wait_drain();
  endtask

  task automatic test_stream_no_gaps(input int count);
    src_gap_max = 0;
    sink_stall_max = 0;
    repeat (count) send_key(random_key());
    wait_drain();
  endtask

  task automatic test_random_idling(input int count);
    src_gap_max = 14;
    sink_stall_max = 14;
    repeat (count) send_key(random_key());
    wait_drain();
  endtask

  task automatic test_backpressure(input int count);
    src_gap_max = 0;
    sink_stall_max = 14;
    repeat (count) send_key(random_key());
    wait_drain();
  endtask

  task automatic test_sparse_source(input int count);
    src_gap_max = 14;
    sink_stall_max = 0;
    repeat (count) send_key(random_key());
    wait_drain();
  endtask

  initial begin
    key_ch.valid = 1'b0;
    key_ch.key   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_keys();
    test_stream_no_gaps(400);
    test_random_idling(700);
    test_backpressure(350);
    test_sparse_source(300);

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_scores.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tmlp_pkg.sv
src/tmlp_key_if.sv
src/tmlp_res_if.sv
src/tmlp_acc.sv
src/tiny_mlp_relu_inference.sv
dv/testbench.sv
